// ===== sv/crcfd_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfd_pkg: shared types and constants for the CRC32 frame deframer
// Item structs for both channels, verdict codes and the bytewise CRC32 step.
// ----------------------------------------------------------------------------
package crcfd_pkg;

  localparam logic [31:0] CRC_POLY        = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ALL_ONES    = 32'hFFFF_FFFF;
  localparam logic [3:0]  NIBBLE_MASK     = 4'hF;
  localparam logic [9:0]  MIN_FRAME_BYTES = 10'd12;
  localparam logic [7:0]  HDR_BYTES       = 8'd5;
  localparam logic [8:0]  FIRST_DATA_POS  = 9'd8;
  localparam logic [8:0]  POS_MAX         = 9'd511;
  localparam logic [7:0]  START_RESET     = 8'd170;

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_LEN   = 3'd1,
    ST_BAD_START = 3'd2,
    ST_BAD_HSUM  = 3'd3,
    ST_BAD_CRC   = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [2:0] status;
    logic [7:0] source_id;
    logic [7:0] dest_id;
    logic [3:0] is_ack_field;
    logic [3:0] need_ack_field;
    logic [7:0] message_type;
    logic [7:0] message_subtype;
    logic [7:0] data_length;
  } out_item_t;

  // Result handed from the parser to the output register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

  // Reflected CRC32, one byte per call
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

// ===== sv/crcfd_parser.sv =====
// ----------------------------------------------------------------------------
// crcfd_parser: frame state and per-byte decode
// Holds the frame state, updates it on each processed byte and forms the
// forwarded data byte or the end-of-buffer verdict.
// ----------------------------------------------------------------------------
module crcfd_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [7:0]           start_byte,
  input  logic                 step,
  input  crcfd_pkg::in_item_t  item,
  output crcfd_pkg::result_t   result
);
  import crcfd_pkg::*;

  logic [8:0]  byte_count;
  logic [7:0]  size_field;
  logic        start_ok;
  logic        header_sum_ok;
  logic [31:0] crc_accumulator;
  logic [7:0]  fcs_bytes [4];
  logic [7:0]  header_bytes [5];

  logic [7:0]  size_field_next;
  logic        start_ok_next;
  logic        header_sum_ok_next;
  logic [31:0] crc_accumulator_next;
  logic [7:0]  fcs_bytes_next [4];
  logic [7:0]  header_bytes_next [5];
  logic [9:0]  crc_start;
  logic [9:0]  pos_w;
  logic [9:0]  total;
  logic [9:0]  crc_off;
  logic        in_payload;
  logic        in_crc;
  logic        hdr_valid;
  logic        fwd;
  status_t     status;
  logic [7:0]  b;

  assign b     = item.rx_byte;
  assign pos_w = {1'b0, byte_count};
  assign total = pos_w + 10'd1;

  always_comb begin
    size_field_next    = (byte_count == 9'd1) ? b : size_field;
    start_ok_next      = (byte_count == 9'd0) ? (b == start_byte) : start_ok;
    header_sum_ok_next = (byte_count == 9'd2) ? (b == 8'(start_byte + size_field_next))
                                              : header_sum_ok;
    crc_start  = 10'd3 + {2'b00, size_field_next};
    crc_off    = pos_w - crc_start;
    in_payload = (byte_count >= 9'd3) && (pos_w < crc_start);
    in_crc     = (pos_w >= crc_start) && (pos_w < crc_start + 10'd4);

    crc_accumulator_next = in_payload ? crc_byte(crc_accumulator, b) : crc_accumulator;
    for (int i = 0; i < 5; i++) begin
      header_bytes_next[i] = header_bytes[i];
      if (in_payload && (byte_count == 9'(3 + i)))
        header_bytes_next[i] = header_bytes[i] | b;
    end
    for (int i = 0; i < 4; i++) begin
      fcs_bytes_next[i] = fcs_bytes[i];
      if (in_crc && (crc_off[1:0] == 2'(i)))
        fcs_bytes_next[i] = fcs_bytes[i] | b;
    end

    hdr_valid = start_ok_next && header_sum_ok_next && (size_field_next >= HDR_BYTES);
    fwd = hdr_valid && (byte_count >= FIRST_DATA_POS) && in_payload;

    // Verdict in priority order
    if (total < MIN_FRAME_BYTES)                       status = ST_BAD_LEN;
    else if (!start_ok_next)                           status = ST_BAD_START;
    else if (size_field_next < HDR_BYTES)              status = ST_BAD_LEN;
    else if (!header_sum_ok_next)                      status = ST_BAD_HSUM;
    else if (total < {2'b00, size_field_next} + 10'd7) status = ST_BAD_LEN;
    else if ((crc_accumulator_next ^ CRC_ALL_ONES) !=
             {fcs_bytes_next[3], fcs_bytes_next[2],
              fcs_bytes_next[1], fcs_bytes_next[0]})
                                                       status = ST_BAD_CRC;
    else                                               status = ST_OK;

    result = '0;
    if (item.buffer_end) begin
      result.valid       = 1'b1;
      result.item.kind   = KIND_VERDICT;
      result.item.status = status;
      if (status == ST_OK) begin
        result.item.source_id       = header_bytes_next[0];
        result.item.dest_id         = header_bytes_next[1];
        result.item.is_ack_field    = header_bytes_next[2][7:4] & NIBBLE_MASK;
        result.item.need_ack_field  = header_bytes_next[2][3:0] & NIBBLE_MASK;
        result.item.message_type    = header_bytes_next[3];
        result.item.message_subtype = header_bytes_next[4];
        result.item.data_length     = size_field_next - HDR_BYTES;
      end
    end else if (fwd) begin
      result.valid          = 1'b1;
      result.item.kind      = KIND_DATA;
      result.item.data_byte = b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.buffer_end)) begin
      byte_count      <= '0;
      size_field      <= '0;
      start_ok        <= 1'b0;
      header_sum_ok   <= 1'b0;
      crc_accumulator <= CRC_ALL_ONES;
      for (int i = 0; i < 4; i++) fcs_bytes[i] <= '0;
      for (int i = 0; i < 5; i++) header_bytes[i] <= '0;
    end else if (step) begin
      if (byte_count != POS_MAX) byte_count <= byte_count + 9'd1;
      size_field      <= size_field_next;
      start_ok        <= start_ok_next;
      header_sum_ok   <= header_sum_ok_next;
      crc_accumulator <= crc_accumulator_next;
      for (int i = 0; i < 4; i++) fcs_bytes[i] <= fcs_bytes_next[i];
      for (int i = 0; i < 5; i++) header_bytes[i] <= header_bytes_next[i];
    end
  end

endmodule

// ===== sv/crcfd_out_stage.sv =====
// ----------------------------------------------------------------------------
// crcfd_out_stage: output register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module crcfd_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  crcfd_pkg::result_t   result,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output crcfd_pkg::out_item_t out_item
);
  import crcfd_pkg::*;

  // Register is free when empty or being taken this cycle
  assign free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load && result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load && result.valid) begin
      out_item <= result.item;
    end
  end

endmodule

// ===== sv/crc32_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// crc32_frame_deframer: SOF/length framed receiver with CRC32 check
// Takes buffer bytes, checks the frame header and payload CRC32, forwards
// payload data bytes and gives a verdict at the end of each buffer.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one buffer byte per item, buffer_end set on the buffer's last byte.
//   out_*  : data items (kind 0) for each payload data byte once the header
//            checks out, and one verdict item (kind 1) per buffer.
//   cfg_*  : writes the expected start-of-frame byte; always ready, write it
//            only while no item is in flight.
//   A byte passes from the input register through the decode logic into the
//   output register, where its result is held until the receiver takes it.
//   Throughput is one byte per cycle while the output is not stalled, set by
//   the combinational bytewise CRC32 update between the two registers.
//   Bytes that yield no result still pass through the decode stage.
//   When out_stall is high with a result held, a byte in the input register
//   is kept and in_stall rises; nothing is lost or repeated.
//   Reset clears the frame state, empties both registers and loads the start
//   byte with 170. After each verdict the frame state returns to reset.
// ----------------------------------------------------------------------------
module crc32_frame_deframer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  crcfd_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output crcfd_pkg::out_item_t out_item
);
  import crcfd_pkg::*;

  logic [7:0] start_value;
  logic       s1_valid;
  in_item_t   s1_item;
  logic       free;
  logic       advance;
  result_t    result;

  // Configuration: one register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_value <= START_RESET;
    end else if (cfg_valid && cfg_ready) begin
      start_value <= cfg_data;
    end
  end

  // Advance the held byte when the output register can take its result
  assign advance  = s1_valid && free;
  assign in_stall = s1_valid && !advance;

  // Input register: hold while stalled, otherwise take the next item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item <= in_item;
    end
  end

  crcfd_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .start_byte (start_value),
    .step       (advance),
    .item       (s1_item),
    .result     (result)
  );

  crcfd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .result    (result),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
